// ----- rtl/ket_pkg.sv -----
// Shared types and constants for the keyed entry table.
// Used by ket_ctrl, ket_dp and keyed_entry_table_unit; no dependencies.
`timescale 1ns / 1ps

package ket_pkg;

	localparam int ENTRIES   = 64;
	localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W     = $clog2(ENTRIES + 1);
	localparam int OUT_CNT_W = 7;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_LOOKUP = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [7:0]  group_id;
		logic [15:0] number;
		logic [15:0] size;
		logic [31:0] hash;
		logic [15:0] note;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture the incoming transaction, clear flags
		logic idx_clr;    // start a scan at entry 0
		logic idx_inc;    // advance the scan
		logic do_add;     // append the captured entry
		logic mark_full;  // add dropped
		logic do_remove;  // move last entry into the hole, shrink count
		logic do_hit;     // record lookup hit
		logic out_load;   // publish the result
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		cmd_t cmd;
		logic full;
		logic empty;
		logic at_last;
		logic key_hit;
		logic grp_hit;
		logic out_busy;
	} dp_stat_t;

endpackage

// ----- rtl/ket_ctrl.sv -----
// Command sequencer for the keyed entry table.
// Depends on ket_pkg; drives ket_dp through dp_cmd_t and watches dp_stat_t.
`timescale 1ns / 1ps

module ket_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ket_pkg::dp_stat_t stat,
	output ket_pkg::dp_cmd_t  dcmd
);
	import ket_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_START  = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_SETTLE = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		dcmd    = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					dcmd.load = 1'b1;
					state_d   = ST_START;
				end
			end
			ST_START: begin
				unique case (stat.cmd)
					CMD_ADD: begin
						if (stat.full) dcmd.mark_full = 1'b1;
						else dcmd.do_add = 1'b1;
						state_d = ST_DONE;
					end
					CMD_REMOVE, CMD_LOOKUP: begin
						if (stat.empty) begin
							state_d = ST_DONE;
						end else begin
							dcmd.idx_clr = 1'b1;
							state_d      = ST_SCAN;
						end
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_SCAN: begin
				if (stat.cmd == CMD_LOOKUP) begin
					if (stat.key_hit) begin
						dcmd.do_hit = 1'b1;
						state_d     = ST_DONE;
					end else if (stat.at_last) begin
						state_d = ST_DONE;
					end else begin
						dcmd.idx_inc = 1'b1;
					end
				end else begin
					if (stat.grp_hit) begin
						dcmd.do_remove = 1'b1;
						// recheck the moved-in entry unless the hole was the tail
						state_d = stat.at_last ? ST_DONE : ST_SETTLE;
					end else if (stat.at_last) begin
						state_d = ST_DONE;
					end else begin
						dcmd.idx_inc = 1'b1;
					end
				end
			end
			ST_SETTLE: state_d = ST_SCAN;
			ST_DONE: begin
				if (!stat.out_busy) begin
					dcmd.out_load = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

endmodule

// ----- rtl/ket_dp.sv -----
// Datapath of the keyed entry table: entry memory, scan index, count, result.
// Depends on ket_pkg; sequenced by ket_ctrl.
`timescale 1ns / 1ps

module ket_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ket_pkg::dp_cmd_t              dcmd,
	output ket_pkg::dp_stat_t             stat,
	input  logic [1:0]                    cmd,
	input  logic [7:0]                    group_id,
	input  logic [15:0]                   item_number,
	input  logic [15:0]                   item_size,
	input  logic [31:0]                   item_hash,
	input  logic [15:0]                   note_handle,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          found,
	output logic [15:0]                   note_out,
	output logic                          table_full,
	output logic [ket_pkg::OUT_CNT_W-1:0] entry_count
);
	import ket_pkg::*;

	entry_t mem_q [ENTRIES];

	cmd_t             cmd_q;
	entry_t           key_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] count_q;
	logic             found_q, full_q;
	logic [15:0]      note_q;
	entry_t           rd_a_q, rd_b_q;
	logic [IDX_W-1:0] rd_a_addr, rd_b_addr;
	logic [CNT_W-1:0] idx_ext;

	logic                 out_valid_q, out_found_q, out_full_q;
	logic [15:0]          out_note_q;
	logic [OUT_CNT_W-1:0] out_count_q;

	// Port A follows the scan index as it will stand next cycle; port B
	// keeps the current tail entry ready for a remove.
	always_comb begin
		if (dcmd.idx_clr) rd_a_addr = '0;
		else if (dcmd.idx_inc) rd_a_addr = idx_q + IDX_W'(1);
		else rd_a_addr = idx_q;
	end
	assign rd_b_addr = IDX_W'(count_q - CNT_W'(1));

	always_ff @(posedge clk) begin
		if (dcmd.do_add) mem_q[count_q[IDX_W-1:0]] <= key_q;
		else if (dcmd.do_remove) mem_q[idx_q] <= rd_b_q;
		rd_a_q <= mem_q[rd_a_addr];
		rd_b_q <= mem_q[rd_b_addr];
	end

	// captured transaction
	always_ff @(posedge clk) begin
		if (dcmd.load) begin
			cmd_q          <= cmd_t'(cmd);
			key_q.group_id <= group_id;
			key_q.number   <= item_number;
			key_q.size     <= item_size;
			key_q.hash     <= item_hash;
			key_q.note     <= note_handle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			count_q <= '0;
			found_q <= 1'b0;
			full_q  <= 1'b0;
			note_q  <= '0;
		end else begin
			if (dcmd.idx_clr) idx_q <= '0;
			else if (dcmd.idx_inc) idx_q <= idx_q + IDX_W'(1);

			if (dcmd.do_add) count_q <= count_q + CNT_W'(1);
			else if (dcmd.do_remove) count_q <= count_q - CNT_W'(1);

			if (dcmd.load) begin
				found_q <= 1'b0;
				full_q  <= 1'b0;
				note_q  <= '0;
			end else begin
				if (dcmd.do_remove || dcmd.do_hit) found_q <= 1'b1;
				if (dcmd.do_hit) note_q <= rd_a_q.note;
				if (dcmd.mark_full) full_q <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (dcmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.out_load) begin
			out_found_q <= found_q;
			out_note_q  <= note_q;
			out_full_q  <= full_q;
			out_count_q <= OUT_CNT_W'(count_q);
		end
	end

	assign idx_ext = CNT_W'(idx_q);

	assign stat.cmd      = cmd_q;
	assign stat.full     = (count_q == CNT_W'(ENTRIES));
	assign stat.empty    = (count_q == '0);
	assign stat.at_last  = ((idx_ext + CNT_W'(1)) >= count_q);
	assign stat.key_hit  = (rd_a_q.number == key_q.number) && (rd_a_q.size == key_q.size)
		&& (rd_a_q.hash == key_q.hash);
	assign stat.grp_hit  = (rd_a_q.group_id == key_q.group_id)
		&& (rd_a_q.number == key_q.number);
	assign stat.out_busy = out_valid_q && !out_ready;

	assign out_valid   = out_valid_q;
	assign found       = out_found_q;
	assign note_out    = out_note_q;
	assign table_full  = out_full_q;
	assign entry_count = out_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ENTRIES))
		else $error("entry count above capacity");

	a_no_add_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.do_add |-> !stat.full)
		else $error("append into a full table");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(dcmd.idx_inc || dcmd.do_remove || dcmd.do_hit) |-> (idx_ext < count_q))
		else $error("scan index past valid entries");

	a_remove_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.do_remove |=> (count_q == $past(count_q) - CNT_W'(1)) && found_q)
		else $error("remove did not shrink the table");

	a_no_result_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result overwritten before it was taken");

endmodule

// ----- rtl/keyed_entry_table_unit.sv -----
// Keyed entry table, top level: ties the command sequencer to the datapath.
// Depends on ket_pkg, ket_ctrl and ket_dp.
`timescale 1ns / 1ps

// The unit holds an unordered table of up to ket_pkg::ENTRIES entries
// (group, number, size, hash, note) in a single memory with one write port
// and two registered read ports. Each input transaction yields exactly one
// result transaction. Commands are handled one at a time: in_ready is high
// only while the unit is idle. An add goes from the start state straight to done.
// Lookup and remove walk the table one entry per cycle through read port A,
// except that a remove passes through a settle state after each deleted
// entry that is not the current tail; in that state the tail entry (kept
// ready on read port B) lands in the hole and is read back for a recheck.
// Deleting the tail entry ends the scan at
// once. The result sits in an output register; the unit accepts the next
// transaction while that result still waits, and only stalls at the end of
// the following command if the earlier result has not yet been taken.
// There is no clearing pass after reset: the entry count starts at zero and
// entries at or above it are never used.

module keyed_entry_table_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [7:0]  group_id,
	input  logic [15:0] item_number,
	input  logic [15:0] item_size,
	input  logic [31:0] item_hash,
	input  logic [15:0] note_handle,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        found,
	output logic [15:0] note_out,
	output logic        table_full,
	output logic [6:0]  entry_count
);
	import ket_pkg::*;

	dp_cmd_t  dcmd;
	dp_stat_t stat;

	// sequencer: idle / start / scan / settle / done
	ket_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.dcmd     (dcmd)
	);

	// memory, scan index, count and result register
	ket_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.dcmd        (dcmd),
		.stat        (stat),
		.cmd         (cmd),
		.group_id    (group_id),
		.item_number (item_number),
		.item_size   (item_size),
		.item_hash   (item_hash),
		.note_handle (note_handle),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.note_out    (note_out),
		.table_full  (table_full),
		.entry_count (entry_count)
	);

endmodule
